FILE: rtl/core/bcs_pkg.sv
package bcs_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_SYS_CLK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_HZ   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_GAP = 2'd2;

    localparam int SYS_CLK_W = 28;
    localparam int HZ_W      = 14;
    localparam int FREQ_W    = 16;
    localparam int WRAP_W    = 16;
    localparam int BEACON_W  = 32;
    localparam int ENTRY_W   = 18;

    localparam logic [SYS_CLK_W-1:0] SYS_CLK_RST  = 28'd125000000;
    localparam logic [HZ_W-1:0]      DEF_HZ_RST   = 14'd4000;
    localparam logic [31:0]          IDLE_GAP_RST = 32'd119969;

    localparam logic [FREQ_W-1:0] HZ_MIN = 16'd1000;
    localparam logic [FREQ_W-1:0] HZ_MAX = 16'd12000;

    // Input item kinds carried on tuser.
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    // Keepalive m-sequence, x^5 + x^2 + 1 from an all-ones seed.
    localparam int PN_LEN = 31;
    localparam int PN_W   = 5;
    localparam logic [PN_W-1:0] PN_LAST = 5'd31;

    function automatic logic [PN_LEN-1:0] pn_gen();
        logic [PN_W-1:0]   r;
        logic              fb;
        logic [PN_LEN-1:0] seq;
        r   = 5'h1F;
        seq = '0;
        for (int i = 0; i < PN_LEN; i++) begin
            fb     = r[4] ^ r[1];
            seq[i] = r[0];
            r      = {r[3:0], fb};
        end
        return seq;
    endfunction

    localparam logic [PN_LEN-1:0] PN_TABLE = pn_gen();

    // Divider between the sequencer and its wrap divider.
    localparam int DIV_STEPS = SYS_CLK_W;
    localparam int DIV_CNT_W = 5;

    typedef struct packed {
        logic                 start;
        logic [SYS_CLK_W-1:0] dividend;
        logic [HZ_W-1:0]      divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [SYS_CLK_W-1:0] quotient;
    } t_div_rsp;

endpackage

FILE: rtl/core/bpsk_chip_sequencer.sv
// Chip sequencer for a differential piezo drive, one result transaction per input item.
// A load, an idle tick or a keepalive end passes only the done state before its result;
// a keepalive chip or the silencing tick passes the tune state first, and a stream chip the
// store read and the tune state; a carrier change adds a wait on the 28-step wrap divider.
// One item is in flight at a time; the next is taken once the result sits in the output
// register. Synchronous active-low reset restores the register defaults and idles all
// streams; the chip store is not cleared, since only entries of the current stream are read.
module bpsk_chip_sequencer #(
    parameter int STREAM_DEPTH = 512
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bcs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bcs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // chip_phase[0], chip_freq_hz[16:1], use_default_freq[17], zero[23:18]
    input  logic [23:0]                      s_axis_tdata,
    // action
    input  logic                             s_axis_tuser,
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // drive_a_inverted[0], drive_b_inverted[1], wrap_minus_one[17:2],
    // compare_level[33:18], tx_busy[34], stream_started[35], load_accepted[36],
    // beacon_total[68:37], zero[71:69]
    output logic [71:0]                      m_axis_tdata
);
    import bcs_pkg::*;

    localparam int AW = $clog2(STREAM_DEPTH);
    localparam int CW = $clog2(STREAM_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STREAM_DEPTH);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_TUNE = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]           r_state;
    logic [SYS_CLK_W-1:0] r_sys_clk;
    logic [HZ_W-1:0]      r_def_hz;
    logic [31:0]          r_gap;

    logic [CW-1:0]        r_fill;
    logic [CW-1:0]        r_play;
    logic                 r_pending;
    logic                 r_active;
    logic                 r_tail;
    logic                 r_pn_run;
    logic [PN_W-1:0]      r_pn_pos;
    logic [31:0]          r_idle;
    logic [BEACON_W-1:0]  r_beacon;
    logic [HZ_W-1:0]      r_cur_hz;
    logic [WRAP_W-1:0]    r_wrap;
    logic [WRAP_W-1:0]    r_level;
    logic                 r_pol_a;
    logic                 r_pol_b;
    logic                 r_started;
    logic                 r_accepted;
    logic [FREQ_W-1:0]    r_tune_hz;
    logic                 r_out_valid;
    logic [71:0]          r_out_data;

    logic [ENTRY_W-1:0]   mem [STREAM_DEPTH];
    logic [ENTRY_W-1:0]   r_rd_data;

    logic                 w_accept;
    logic                 w_busy;
    logic                 w_mem_we;
    logic                 w_mem_re;
    logic                 w_out_load;
    logic [CW-1:0]        w_play_idx;
    logic [CW-1:0]        n_fill;
    logic [CW-1:0]        n_play;
    logic [31:0]          n_idle;
    logic [HZ_W-1:0]      w_hz;
    logic [16:0]          w_wrap_full;
    t_div_req             w_div_req;
    t_div_rsp             w_div_rsp;

    assign s_axis_tready = i_rst_n && (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_busy        = r_pending || r_active || r_tail;
    assign w_out_load    = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);

    assign w_play_idx = (r_pending && !r_active) ? '0 : r_play;
    assign n_fill     = r_fill + 1'b1;
    assign n_play     = w_play_idx + 1'b1;
    assign n_idle     = r_idle + 32'd1;

    assign w_mem_we = w_accept && (s_axis_tuser == ACT_LOAD) && !w_busy && (r_fill < DEPTH_C);
    assign w_mem_re = w_accept && (s_axis_tuser == ACT_TICK) && !r_tail
                      && (r_pending || r_active);

    // Carrier clamp to the legal hop band.
    always_comb begin
        if (r_tune_hz < HZ_MIN) begin
            w_hz = HZ_W'(HZ_MIN);
        end else if (r_tune_hz > HZ_MAX) begin
            w_hz = HZ_W'(HZ_MAX);
        end else begin
            w_hz = r_tune_hz[HZ_W-1:0];
        end
    end

    // Wrap clamped to 2..65536 counts.
    always_comb begin
        if (w_div_rsp.quotient < 28'd2) begin
            w_wrap_full = 17'd2;
        end else if (w_div_rsp.quotient > 28'd65536) begin
            w_wrap_full = 17'd65536;
        end else begin
            w_wrap_full = w_div_rsp.quotient[16:0];
        end
    end

    assign w_div_req.start    = (r_state == ST_TUNE) && (w_hz != r_cur_hz);
    assign w_div_req.dividend = r_sys_clk;
    assign w_div_req.divisor  = w_hz;

    bcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Loads are refused while a stream is busy and playback only reads while busy,
    // so a write and a read never touch the store in the same transaction.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[r_fill[AW-1:0]] <= s_axis_tdata[ENTRY_W-1:0];
        end
        if (w_mem_re) begin
            r_rd_data <= mem[w_play_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sys_clk   <= SYS_CLK_RST;
            r_def_hz    <= DEF_HZ_RST;
            r_gap       <= IDLE_GAP_RST;
            r_fill      <= '0;
            r_play      <= '0;
            r_pending   <= 1'b0;
            r_active    <= 1'b0;
            r_tail      <= 1'b0;
            r_pn_run    <= 1'b0;
            r_pn_pos    <= '0;
            r_idle      <= '0;
            r_beacon    <= '0;
            r_cur_hz    <= '0;
            r_wrap      <= '0;
            r_level     <= '0;
            r_pol_a     <= 1'b0;
            r_pol_b     <= 1'b0;
            r_started   <= 1'b0;
            r_accepted  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SYS_CLK:  r_sys_clk <= i_cfg_data[SYS_CLK_W-1:0];
                    CFG_DEF_HZ:   r_def_hz  <= i_cfg_data[HZ_W-1:0];
                    CFG_IDLE_GAP: r_gap     <= i_cfg_data;
                    default: ;
                endcase
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_started  <= w_mem_re && (w_play_idx == '0);
                        r_accepted <= w_mem_we;
                        if (s_axis_tuser == ACT_LOAD) begin
                            if (w_mem_we) begin
                                r_fill <= n_fill;
                                // A full buffer arms the stream as if marked last.
                                if (s_axis_tlast || n_fill >= DEPTH_C) begin
                                    r_pending <= 1'b1;
                                end
                            end
                            r_state <= ST_DONE;
                        end else if (r_tail) begin
                            r_tail    <= 1'b0;
                            r_pol_a   <= 1'b0;
                            r_pol_b   <= 1'b0;
                            r_fill    <= '0;
                            r_pn_run  <= 1'b0;
                            r_pn_pos  <= '0;
                            r_idle    <= '0;
                            r_tune_hz <= FREQ_W'(r_def_hz);
                            r_state   <= ST_TUNE;
                        end else if (r_pending || r_active) begin
                            r_pending <= 1'b0;
                            r_play    <= n_play;
                            r_active  <= (n_play < r_fill);
                            r_tail    <= (n_play >= r_fill);
                            r_state   <= ST_READ;
                        end else if (r_pn_run) begin
                            if (r_pn_pos >= PN_LAST) begin
                                r_pn_run <= 1'b0;
                                r_pn_pos <= '0;
                                r_idle   <= '0;
                                r_beacon <= r_beacon + 1'b1;
                                r_pol_a  <= 1'b0;
                                r_pol_b  <= 1'b0;
                                r_state  <= ST_DONE;
                            end else begin
                                r_pol_a   <= ~PN_TABLE[r_pn_pos];
                                r_pol_b   <= PN_TABLE[r_pn_pos];
                                r_pn_pos  <= r_pn_pos + 1'b1;
                                r_tune_hz <= FREQ_W'(r_def_hz);
                                r_state   <= ST_TUNE;
                            end
                        end else begin
                            r_idle <= n_idle;
                            if (n_idle >= r_gap) begin
                                r_pn_run <= 1'b1;
                                r_pn_pos <= '0;
                            end
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_READ: begin
                    r_pol_a   <= ~r_rd_data[0];
                    r_pol_b   <= r_rd_data[0];
                    r_tune_hz <= r_rd_data[17] ? FREQ_W'(r_def_hz) : r_rd_data[16:1];
                    r_state   <= ST_TUNE;
                end
                ST_TUNE: begin
                    r_state <= (w_hz == r_cur_hz) ? ST_DONE : ST_DIV;
                end
                ST_DIV: begin
                    if (w_div_rsp.done) begin
                        r_wrap   <= WRAP_W'(w_wrap_full - 17'd1);
                        r_level  <= WRAP_W'(w_wrap_full >> 1);
                        r_cur_hz <= w_hz;
                        r_state  <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_load) begin
                        r_out_data <= {3'b000, r_beacon, r_accepted, r_started, w_busy,
                                       r_level, r_wrap, r_pol_b, r_pol_a};
                        r_state    <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // At most one of the stream phases is ever set.
    a_one_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({r_pending, r_active, r_tail}) <= 1)
        else $error("stream phase flags overlap");

    // A playing stream never runs past the loaded chips.
    a_play_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_play < r_fill) && (r_play != '0))
        else $error("play index out of range");

    // A stored load advances the fill count by one.
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |=> (r_fill == $past(n_fill)))
        else $error("fill count did not advance");

    // The divider only runs while the sequencer waits for it.
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == ST_DIV))
        else $error("divider finished outside its wait state");

endmodule

FILE: rtl/core/bcs_div.sv
module bcs_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bcs_pkg::t_div_req i_req,
    output bcs_pkg::t_div_rsp o_rsp
);
    import bcs_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [HZ_W-1:0]      r_rem;
    logic [HZ_W-1:0]      r_den;
    logic [SYS_CLK_W-1:0] r_quo;

    logic [HZ_W:0] w_trial;
    logic [HZ_W:0] w_diff;
    logic          w_fits;
    logic          w_last;

    // Restoring division, one quotient bit per cycle; the dividend shifts out of
    // the top of r_quo while quotient bits shift in at the bottom.
    assign w_trial = {r_rem, r_quo[SYS_CLK_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_last  = (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_den  <= i_req.divisor;
                r_quo  <= i_req.dividend;
            end else if (r_busy) begin
                r_rem <= w_fits ? w_diff[HZ_W-1:0] : w_trial[HZ_W-1:0];
                r_quo <= {r_quo[SYS_CLK_W-2:0], w_fits};
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
